[src/compass_heading_with_calibration_defines.svh]
// assertion helpers, clocked on clk and disabled while arst_n is low
`ifndef COMPASS_HEADING_WITH_CALIBRATION_DEFINES_SVH
`define COMPASS_HEADING_WITH_CALIBRATION_DEFINES_SVH

// same-cycle implication
`define CHC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CHC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/chc_pkg.sv]
`default_nettype none

package chc_pkg;

	localparam int AXIS_W    = 13;
	localparam int SUM_W     = 14;
	localparam int DIFF_W    = 16;
	localparam int MAG_W     = 14;
	localparam int FRAC_W    = 16;
	localparam int CW        = 36;
	localparam int DIGIT_W   = 12;
	localparam int DIGITS    = CW / DIGIT_W;
	localparam int ZW        = 28;
	localparam int ANG_W     = 26;
	localparam int TAB_W     = 25;
	localparam int TAB_IDX_W = 5;
	localparam int HEAD_W    = 12;
	localparam int CNT_W     = 4;
	localparam int TOT_W     = 28;

	// 900 degrees-tenths in the 2^-16 fixed point of the angle unit
	localparam logic [ANG_W-1:0] ANG_MAX = 26'd58982400;

	localparam logic [HEAD_W-1:0] HEAD_FULL = 12'd3600;
	localparam logic [HEAD_W-1:0] HEAD_HALF = 12'd1800;
	localparam logic [HEAD_W-1:0] HEAD_QTR  = 12'd900;
	localparam logic [HEAD_W-1:0] HEAD_3QTR = 12'd2700;
	localparam logic [HEAD_W-1:0] ARM_MAX   = 12'd100;
	localparam logic [HEAD_W-1:0] WIN_LO    = 12'd1900;
	localparam logic [HEAD_W-1:0] WIN_HI    = 12'd2500;

	// atan(2^-i) in 2^-16 tenth-degree units
	function automatic logic [TAB_W-1:0] atan_entry(input logic [TAB_IDX_W-1:0] idx);
		logic [TAB_W-1:0] v;
		case (idx)
			5'd0:    v = 25'd29491200;
			5'd1:    v = 25'd17409672;
			5'd2:    v = 25'd9198793;
			5'd3:    v = 25'd4669451;
			5'd4:    v = 25'd2343786;
			5'd5:    v = 25'd1173036;
			5'd6:    v = 25'd586661;
			5'd7:    v = 25'd293348;
			5'd8:    v = 25'd146676;
			5'd9:    v = 25'd73339;
			5'd10:   v = 25'd36669;
			5'd11:   v = 25'd18335;
			5'd12:   v = 25'd9167;
			5'd13:   v = 25'd4584;
			5'd14:   v = 25'd2292;
			5'd15:   v = 25'd1146;
			5'd16:   v = 25'd573;
			5'd17:   v = 25'd286;
			5'd18:   v = 25'd143;
			5'd19:   v = 25'd72;
			5'd20:   v = 25'd36;
			5'd21:   v = 25'd18;
			5'd22:   v = 25'd9;
			5'd23:   v = 25'd4;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

[src/chc_cordic.sv]
`default_nettype none
`include "compass_heading_with_calibration_defines.svh"

module chc_cordic import chc_pkg::*; #(
	parameter int ITERATIONS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [MAG_W-1:0] ax,
	input  logic [MAG_W-1:0] ay,
	output logic             done,
	output logic [ANG_W-1:0] angle
);

	localparam int ITER_W = $clog2(ITERATIONS);
	localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(ITERATIONS - 1);
	localparam int DCNT_W = $clog2(DIGITS);
	localparam logic [DCNT_W-1:0] DIGIT_LAST = DCNT_W'(DIGITS - 1);

	typedef enum logic [1:0] {S_IDLE, S_LOAD, S_DIGIT, S_DONE} state_t;

	state_t state_q;
	logic [ITER_W-1:0] iter_q;
	logic [DCNT_W-1:0] dcnt_q;

	logic signed [CW-1:0] x_q, y_q, xs_q, ys_q;
	logic signed [ZW-1:0] z_q;
	logic cx_q, cy_q, dir_q;

	logic signed [CW-1:0] x_sh, y_sh;
	logic [TAB_W-1:0] tab;
	logic signed [ZW-1:0] tab_ext;
	logic [DIGIT_W:0] sum_x, sum_y;

	assign x_sh = x_q >>> iter_q;
	assign y_sh = y_q >>> iter_q;
	assign tab = atan_entry(TAB_IDX_W'(iter_q));
	assign tab_ext = $signed(ZW'(tab));

	// one digit of both rotations per cycle, lsb digit first, carries held between digits
	assign sum_x = {1'b0, x_q[DIGIT_W-1:0]}
		+ {1'b0, (dir_q ? ys_q[DIGIT_W-1:0] : ~ys_q[DIGIT_W-1:0])}
		+ {{DIGIT_W{1'b0}}, cx_q};
	assign sum_y = {1'b0, y_q[DIGIT_W-1:0]}
		+ {1'b0, (dir_q ? ~xs_q[DIGIT_W-1:0] : xs_q[DIGIT_W-1:0])}
		+ {{DIGIT_W{1'b0}}, cy_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			iter_q  <= '0;
			dcnt_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						iter_q  <= '0;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					dcnt_q  <= '0;
					state_q <= S_DIGIT;
				end
				S_DIGIT: begin
					if (dcnt_q == DIGIT_LAST) begin
						if (iter_q == ITER_LAST) begin
							state_q <= S_DONE;
						end else begin
							iter_q  <= iter_q + ITER_W'(1);
							state_q <= S_LOAD;
						end
					end else begin
						dcnt_q <= dcnt_q + DCNT_W'(1);
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					x_q <= CW'({ax, {FRAC_W{1'b0}}});
					y_q <= CW'({ay, {FRAC_W{1'b0}}});
					z_q <= '0;
				end
			end
			S_LOAD: begin
				xs_q  <= x_sh;
				ys_q  <= y_sh;
				dir_q <= !y_q[CW-1];
				cx_q  <= y_q[CW-1];
				cy_q  <= !y_q[CW-1];
				z_q   <= y_q[CW-1] ? z_q - tab_ext : z_q + tab_ext;
			end
			S_DIGIT: begin
				x_q  <= {sum_x[DIGIT_W-1:0], x_q[CW-1:DIGIT_W]};
				y_q  <= {sum_y[DIGIT_W-1:0], y_q[CW-1:DIGIT_W]};
				xs_q <= xs_q >> DIGIT_W;
				ys_q <= ys_q >> DIGIT_W;
				cx_q <= sum_x[DIGIT_W];
				cy_q <= sum_y[DIGIT_W];
			end
			default: ;
		endcase
	end

	assign done = (state_q == S_DONE);

	always_comb begin
		if (z_q[ZW-1])
			angle = '0;
		else if ($unsigned(z_q) > ZW'(ANG_MAX))
			angle = ANG_MAX;
		else
			angle = z_q[ANG_W-1:0];
	end

	`CHC_ASSERT_IMPL(a_x_positive, state_q == S_LOAD, !x_q[CW-1], "cordic x went negative")
	`CHC_ASSERT_IMPL(a_done_last, done, iter_q == ITER_LAST, "cordic finished early")

endmodule

`default_nettype wire

[src/compass_heading_with_calibration.sv]
// Compass heading with hard-iron calibration. Each input beat is either a start beat
// (tuser 0), which opens a calibration run, or a sample beat (tuser 1) carrying the raw
// X and Y register bytes. Every input beat gives one output beat with the heading in
// tenths of a degree (0..3599), counterclockwise from +X, a calibrating flag and the
// circle count. A sample that needs the angle unit waits for it to finish: the angle
// unit runs each micro-rotation as a load step and then one digit-serial add per 12-bit
// digit over its 36-bit datapath. Start beats and samples on an axis skip the angle unit.
// The next beat is taken the cycle after the previous one has moved into the output
// register, so the block takes no new beat while one is in flight. circles_needed is to
// be written through cfg_wr_en / cfg_wr_data only while the block is idle; the block
// itself does not enforce this.
`default_nettype none
`include "compass_heading_with_calibration_defines.svh"

module compass_heading_with_calibration import chc_pkg::*; #(
	parameter int ANGLE_ITERATIONS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [3:0]  cfg_wr_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// x_low_byte, x_high_byte, y_low_byte, y_high_byte
	input  logic [31:0] s_axis_tdata,
	// kind
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// heading_tenths, calibrating, circles_counted, zero fill
	output logic [23:0] m_axis_tdata,
	// heading_valid
	output logic        m_axis_tuser
);

	localparam int M_DATA_W = 24;
	localparam int M_USED_W = HEAD_W + 1 + CNT_W;

	typedef enum logic [2:0] {S_IDLE, S_PREP, S_AXIS, S_ANGLE, S_POST, S_OUT} state_t;
	typedef enum logic [1:0] {Q_FIRST, Q_SECOND, Q_THIRD, Q_FOURTH} quad_t;

	state_t state_q;
	quad_t  quad_q;

	logic [CNT_W-1:0] needed_q, circle_q;
	logic armed_q;
	logic signed [AXIS_W-1:0] x_hi_q, x_lo_q, y_hi_q, y_lo_q;
	logic signed [SUM_W-1:0] x_off_q, y_off_q;

	logic [31:0] in_data_q;
	logic kind_q;
	logic signed [DIFF_W-1:0] dx_q, dy_q;
	logic [HEAD_W-1:0] head_q;
	logic hvalid_q;

	logic out_valid_q;
	logic [M_DATA_W-1:0] out_data_q;
	logic out_user_q;

	logic signed [AXIS_W-1:0] x_s, y_s;
	logic [MAG_W-1:0] ax, ay;
	logic cordic_start, cordic_done;
	logic [ANG_W-1:0] cordic_angle;
	logic [TOT_W-1:0] z_ext, total;
	logic [HEAD_W-1:0] head_raw, head_wrap;
	logic armed_n, latch_n;
	logic [CNT_W-1:0] cc_n;
	logic out_load;

	assign x_s = $signed({in_data_q[15:8], in_data_q[7:3]});
	assign y_s = $signed({in_data_q[31:24], in_data_q[23:19]});

	// magnitudes stay below 2^14, so the negation fits
	assign ax = dx_q[DIFF_W-1] ? MAG_W'(-dx_q) : MAG_W'(dx_q);
	assign ay = dy_q[DIFF_W-1] ? MAG_W'(-dy_q) : MAG_W'(dy_q);
	assign cordic_start = (state_q == S_AXIS) && (dx_q != '0) && (dy_q != '0);

	chc_cordic #(
		.ITERATIONS(ANGLE_ITERATIONS)
	) u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cordic_start),
		.ax    (ax),
		.ay    (ay),
		.done  (cordic_done),
		.angle (cordic_angle)
	);

	assign z_ext = TOT_W'(cordic_angle);

	always_comb begin
		case (quad_q)
			Q_FIRST:  total = z_ext;
			Q_SECOND: total = {HEAD_HALF, {FRAC_W{1'b0}}} - z_ext;
			Q_THIRD:  total = {HEAD_HALF, {FRAC_W{1'b0}}} + z_ext;
			default:  total = {HEAD_FULL, {FRAC_W{1'b0}}} - z_ext;
		endcase
	end

	assign head_raw  = total[TOT_W-1:FRAC_W];
	assign head_wrap = (head_raw >= HEAD_FULL) ? head_raw - HEAD_FULL : head_raw;

	// circle counting on a calibrating sample
	always_comb begin
		armed_n = armed_q;
		cc_n    = circle_q;
		latch_n = 1'b0;
		if (head_q <= ARM_MAX)
			armed_n = 1'b0;
		if (head_q >= WIN_LO && head_q < WIN_HI && !armed_n) begin
			cc_n    = cc_n + CNT_W'(1);
			armed_n = 1'b1;
		end
		if (cc_n >= needed_q || cc_n == '0) begin
			latch_n = 1'b1;
			cc_n    = '0;
		end
	end

	assign out_load = (state_q == S_OUT) && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			needed_q    <= CNT_W'(3);
			circle_q    <= '0;
			armed_q     <= 1'b0;
			x_hi_q      <= '0;
			x_lo_q      <= '0;
			y_hi_q      <= '0;
			y_lo_q      <= '0;
			x_off_q     <= '0;
			y_off_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en)
				needed_q <= cfg_wr_data;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid)
						state_q <= S_PREP;
				end
				S_PREP: begin
					if (!kind_q) begin
						circle_q <= CNT_W'(1);
						armed_q  <= 1'b1;
						x_hi_q   <= '0;
						x_lo_q   <= '0;
						y_hi_q   <= '0;
						y_lo_q   <= '0;
						x_off_q  <= '0;
						y_off_q  <= '0;
						state_q  <= S_OUT;
					end else begin
						if (circle_q != '0) begin
							if (x_s > x_hi_q) x_hi_q <= x_s;
							if (x_s < x_lo_q) x_lo_q <= x_s;
							if (y_s > y_hi_q) y_hi_q <= y_s;
							if (y_s < y_lo_q) y_lo_q <= y_s;
						end
						state_q <= S_AXIS;
					end
				end
				S_AXIS: begin
					state_q <= cordic_start ? S_ANGLE : S_POST;
				end
				S_ANGLE: begin
					if (cordic_done)
						state_q <= S_POST;
				end
				S_POST: begin
					if (circle_q != '0) begin
						armed_q  <= armed_n;
						circle_q <= cc_n;
						if (latch_n) begin
							x_off_q <= SUM_W'(x_hi_q) + SUM_W'(x_lo_q);
							y_off_q <= SUM_W'(y_hi_q) + SUM_W'(y_lo_q);
						end
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_axis_tvalid) begin
			in_data_q <= s_axis_tdata;
			kind_q    <= s_axis_tuser;
		end
		case (state_q)
			S_PREP: begin
				hvalid_q <= kind_q;
				head_q   <= '0;
				if (circle_q != '0) begin
					dx_q <= DIFF_W'(x_s);
					dy_q <= DIFF_W'(y_s);
				end else begin
					// twice the scale keeps the half-sum offset exact
					dx_q <= (DIFF_W'(x_s) <<< 1) - DIFF_W'(x_off_q);
					dy_q <= (DIFF_W'(y_s) <<< 1) - DIFF_W'(y_off_q);
				end
			end
			S_AXIS: begin
				if (dy_q == '0)
					head_q <= dx_q[DIFF_W-1] ? HEAD_HALF : '0;
				else if (dx_q == '0)
					head_q <= dy_q[DIFF_W-1] ? HEAD_3QTR : HEAD_QTR;
				case ({dx_q[DIFF_W-1], dy_q[DIFF_W-1]})
					2'b00:   quad_q <= Q_FIRST;
					2'b10:   quad_q <= Q_SECOND;
					2'b11:   quad_q <= Q_THIRD;
					default: quad_q <= Q_FOURTH;
				endcase
			end
			S_ANGLE: begin
				if (cordic_done)
					head_q <= head_wrap;
			end
			default: ;
		endcase
		if (out_load) begin
			out_data_q <= {{(M_DATA_W - M_USED_W){1'b0}}, circle_q, (circle_q != '0), head_q};
			out_user_q <= hvalid_q;
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	`CHC_ASSERT_IMPL(a_head_range, m_axis_tvalid, out_data_q[HEAD_W-1:0] < HEAD_FULL,
		"heading out of range")
	`CHC_ASSERT_IMPL(a_start_result, m_axis_tvalid && !m_axis_tuser,
		out_data_q[HEAD_W-1:0] == '0 && out_data_q[M_USED_W-1:HEAD_W+1] == CNT_W'(1),
		"start beat result wrong")
	`CHC_ASSERT_NEXT(a_out_loaded, out_load, m_axis_tvalid && s_axis_tready,
		"result not presented after load")

endmodule

`default_nettype wire
